>>> rtl/e2c_pkg.sv
// shared types and constants of the epoch to calendar converter
package e2c_pkg;

  // working remainder: local seconds reach 2^32 - 1 plus fourteen hours and more
  localparam int REM_W   = 33;
  localparam int DAYS_W  = 16;
  localparam int QUO_W   = 16;
  localparam int CNT_W   = 4;
  localparam int EPOCH_W = 32;
  localparam int OFF_W   = 5;
  localparam int YEAR_W  = 12;

  localparam int SECS_PER_DAY  = 86400;
  localparam int SECS_PER_HOUR = 3600;
  localparam int SECS_PER_MIN  = 60;
  localparam int DAYS_PER_QUAD = 1461;
  localparam int DAYS_LEAP_YR  = 366;
  localparam int DAYS_NORM_YR  = 365;

  // four-year blocks start at 1968-01-01, a leap year
  localparam int BASE_YEAR     = 1968;
  localparam int DAYS_TO_EPOCH = 731;
  // day number of 2100-03-01; from there on a missing feb 29 is inserted
  localparam int DAY_2100_MAR1 = 47541;

  // quotient bit counts minus one for each division pass
  localparam int DAY_STEPS  = 15;
  localparam int HOUR_STEPS = 4;
  localparam int MIN_STEPS  = 5;
  localparam int QUAD_STEPS = 5;

  localparam logic signed [OFF_W-1:0] OFFSET_RESET = 5'sd8;

  typedef logic signed [OFF_W-1:0] offset_t;

  typedef struct packed {
    logic [EPOCH_W-1:0] epoch_seconds;
  } stamp_t;

  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [3:0]        month;
    logic [4:0]        day;
    logic [4:0]        hour;
    logic [5:0]        minute;
    logic [5:0]        second;
    logic [2:0]        weekday;
  } cal_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DAY,
    ST_HOUR,
    ST_MIN,
    ST_QUAD,
    ST_YEAR,
    ST_MONTH,
    ST_DONE
  } e2c_state_t;

  typedef struct packed {
    logic idle;
    logic done;
  } core_stat_t;

endpackage

>>> rtl/e2c_chan_if.sv
// valid/ready channel carrying one word of any payload type
interface e2c_chan_if #(parameter type data_t = logic) ();
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/e2c_trial_sub.sv
// shared compare and subtract unit
module e2c_trial_sub import e2c_pkg::*; (
  input  logic [REM_W-1:0] a,
  input  logic [REM_W-1:0] b,
  output logic [REM_W-1:0] diff,
  output logic             ge
);

  logic [REM_W:0] full;

  assign full = {1'b0, a} - {1'b0, b};
  assign ge   = !full[REM_W];
  assign diff = full[REM_W-1:0];

endmodule

>>> rtl/e2c_core.sv
// sequencer and datapath of the iterative calendar conversion
module e2c_core import e2c_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [EPOCH_W-1:0] epoch,
  input  offset_t            offset,
  input  logic               res_take,
  output core_stat_t         stat,
  output cal_t               res
);

  localparam logic [REM_W-1:0] DVS_DAY  = REM_W'(SECS_PER_DAY)  << DAY_STEPS;
  localparam logic [REM_W-1:0] DVS_HOUR = REM_W'(SECS_PER_HOUR) << HOUR_STEPS;
  localparam logic [REM_W-1:0] DVS_MIN  = REM_W'(SECS_PER_MIN)  << MIN_STEPS;
  localparam logic [REM_W-1:0] DVS_QUAD = REM_W'(DAYS_PER_QUAD) << QUAD_STEPS;

  e2c_state_t       state, state_next;
  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] dvs;
  logic [QUO_W-1:0] quo;
  logic [CNT_W-1:0] cnt;
  logic [DAYS_W-1:0] days;
  logic [1:0]       yq;
  logic [3:0]       mon;
  logic [4:0]       hour_r;
  logic [5:0]       minute_r;
  logic [5:0]       second_r;

  logic [REM_W-1:0] operand;
  logic [REM_W-1:0] diff;
  logic             ge;
  logic             take;
  logic             last;
  logic [QUO_W-1:0] quo_next;

  logic signed [17:0]  off_sec;
  logic signed [34:0]  local_sum;
  logic [REM_W-1:0]    local_sec;
  logic [DAYS_W-1:0]   days_adj;

  function automatic logic [8:0] month_len(input logic [3:0] m, input logic leap);
    logic [8:0] len;
    unique case (m)
      4'd1:                      len = leap ? 9'd29 : 9'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 9'd30;
      default:                   len = 9'd31;
    endcase
    return len;
  endfunction

  // 8 is 1 mod 7, so octal digits fold
  function automatic logic [2:0] iso_weekday(input logic [DAYS_W-1:0] d);
    logic [DAYS_W-1:0] t;
    logic [5:0]        s;
    logic [3:0]        f;
    t = d + DAYS_W'(3);
    s = 6'(t[2:0]) + 6'(t[5:3]) + 6'(t[8:6]) + 6'(t[11:9]) + 6'(t[14:12])
      + 6'(t[15]);
    f = 4'(s[2:0]) + 4'(s[5:3]);
    if (f >= 4'd7) begin
      f = f - 4'd7;
    end
    return f[2:0] + 3'd1;
  endfunction

  // local seconds, clamped at zero
  assign off_sec   = offset * 18'sd3600;
  assign local_sum = $signed({3'b000, epoch}) + 35'(off_sec);
  assign local_sec = local_sum[34] ? '0 : local_sum[REM_W-1:0];

  // day count moved onto 1968 blocks, with a phantom feb 29 in 2100
  assign days_adj = days + DAYS_W'(DAYS_TO_EPOCH)
                  + DAYS_W'(days >= DAYS_W'(DAY_2100_MAR1));

  e2c_trial_sub u_sub (
    .a    (rem),
    .b    (operand),
    .diff (diff),
    .ge   (ge)
  );

  assign last     = (cnt == '0);
  assign quo_next = {quo[QUO_W-2:0], ge};

  // shared unit operand and step decision
  always_comb begin
    operand = dvs;
    take    = ge;
    unique case (state)
      ST_YEAR: begin
        operand = (yq == 2'd0) ? REM_W'(DAYS_LEAP_YR) : REM_W'(DAYS_NORM_YR);
        take    = ge && (yq != 2'd3);
      end
      ST_MONTH: begin
        operand = REM_W'(month_len(mon, yq == 2'd0));
        take    = ge && (mon != 4'd11);
      end
      default: begin
        operand = dvs;
        take    = ge;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (start) state_next = ST_DAY;
      ST_DAY:   if (last) state_next = ST_HOUR;
      ST_HOUR:  if (last) state_next = ST_MIN;
      ST_MIN:   if (last) state_next = ST_QUAD;
      ST_QUAD:  if (last) state_next = ST_YEAR;
      ST_YEAR:  if (!take) state_next = ST_MONTH;
      ST_MONTH: if (!take) state_next = ST_DONE;
      ST_DONE:  if (res_take) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // status and result
  always_comb begin
    stat.idle   = (state == ST_IDLE);
    stat.done   = (state == ST_DONE);
    res.year    = YEAR_W'(BASE_YEAR) + {4'b0000, quo[5:0], 2'b00} + YEAR_W'(yq);
    res.month   = mon + 4'd1;
    res.day     = rem[4:0] + 5'd1;
    res.hour    = hour_r;
    res.minute  = minute_r;
    res.second  = second_r;
    res.weekday = iso_weekday(days);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          rem <= local_sec;
          dvs <= DVS_DAY;
          cnt <= CNT_W'(DAY_STEPS);
          quo <= '0;
        end
      end
      ST_DAY, ST_HOUR, ST_MIN, ST_QUAD: begin
        if (ge) begin
          rem <= diff;
        end
        quo <= quo_next;
        dvs <= dvs >> 1;
        cnt <= cnt - CNT_W'(1);
        if (last) begin
          unique case (state)
            ST_DAY: begin
              days <= quo_next;
              dvs  <= DVS_HOUR;
              cnt  <= CNT_W'(HOUR_STEPS);
              quo  <= '0;
            end
            ST_HOUR: begin
              hour_r <= quo_next[4:0];
              dvs    <= DVS_MIN;
              cnt    <= CNT_W'(MIN_STEPS);
              quo    <= '0;
            end
            ST_MIN: begin
              minute_r <= quo_next[5:0];
              second_r <= ge ? diff[5:0] : rem[5:0];
              rem      <= REM_W'(days_adj);
              dvs      <= DVS_QUAD;
              cnt      <= CNT_W'(QUAD_STEPS);
              quo      <= '0;
              yq       <= 2'd0;
              mon      <= 4'd0;
            end
            default: begin
              // block index stays in quo
            end
          endcase
        end
      end
      ST_YEAR: begin
        if (take) begin
          rem <= diff;
          yq  <= yq + 2'd1;
        end
      end
      ST_MONTH: begin
        if (take) begin
          rem <= diff;
          mon <= mon + 4'd1;
        end
      end
      default: begin
        // result held until taken
      end
    endcase
  end

  a_year_in_block: assert property (@(posedge clk) disable iff (rst)
    state == ST_YEAR |-> rem < REM_W'(DAYS_PER_QUAD))
    else $error("day of block out of range");

  a_month_in_year: assert property (@(posedge clk) disable iff (rst)
    state == ST_MONTH |-> rem < REM_W'(DAYS_LEAP_YR))
    else $error("day of year out of range");

  a_done_fields: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE |-> mon <= 4'd11 && rem < REM_W'(31) && hour_r < 5'd24)
    else $error("calendar fields out of range");

  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE && start |=> state == ST_DAY)
    else $error("accepted word did not start conversion");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && !res_take |=> state == ST_DONE && $stable(rem) && $stable(mon))
    else $error("waiting result changed");

endmodule

>>> rtl/epoch_to_calendar_weekday.sv
// top level: seconds since 1970 to local calendar date, time and iso weekday
// the conversion runs step by step on the one shared compare-subtract unit:
//   16, 5, 6 and 6 division steps, 1 to 4 year steps and 1 to 12 month
//   steps, then the result is loaded into the output register
// flow: a new word is taken only while the sequencer is idle; a finished
//   result waits in the output register while the next word is converted
// reset (rst, synchronous): sequencer idle, result register empty, offset 8
module epoch_to_calendar_weekday import e2c_pkg::*; (
  input logic        clk,
  input logic        rst,
  e2c_chan_if.sink   stamp,
  e2c_chan_if.source date,
  e2c_chan_if.sink   cfg
);

  offset_t    offset;     // whole-hour zone offset
  core_stat_t stat;
  cal_t       res;
  logic       start;
  logic       res_take;

  // offset register, written any time (only while idle by contract)
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= OFFSET_RESET;
    end else if (cfg.valid) begin
      offset <= cfg.data;
    end
  end

  // one word in flight inside the sequencer
  assign stamp.ready = stat.idle;
  assign start       = stamp.valid && stat.idle;

  // result moves out when the output register is empty or drains this cycle
  assign res_take = stat.done && (!date.valid || date.ready);

  e2c_core u_core (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .epoch    (stamp.data.epoch_seconds),
    .offset   (offset),
    .res_take (res_take),
    .stat     (stat),
    .res      (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      date.valid <= 1'b0;
    end else if (res_take) begin
      date.valid <= 1'b1;
    end else if (date.ready) begin
      date.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      date.data <= res;
    end
  end

endmodule

>>> test/testbench.sv
// self-checking bench for the epoch seconds to local calendar and weekday converter
`timescale 1ns / 100ps

module testbench;
  import e2c_pkg::*;

  // the slowest correct run is about 1925 words
  localparam int CYCLE_LIMIT  = 1_000_000;
  // let any stray result show up after the drain
  localparam int DRAIN_CYCLES = 64;
  localparam int RANDOM_WORDS = 1900;
  localparam int PHASES       = 6;
  localparam int REPORT_MAX   = 10;

  // one pending conversion: the stamp that went in and the date it must produce
  typedef struct packed {
    logic [EPOCH_W-1:0] secs;
    cal_t               cal;
  } due_t;

  // tracks the offset register and the dates still owed by the converter
  class cal_scoreboard;
    offset_t offset;
    due_t    due_dates[$];
    int      noted;
    int      checked;
    int      errors;

    function new();
      offset = OFFSET_RESET;
    endfunction

    function bit leap_year(int y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    // local calendar date, time of day and iso weekday of one stamp
    function cal_t local_calendar(logic [EPOCH_W-1:0] secs);
      longint local_s;
      longint days;
      longint sod;
      int     yr;
      int     mo;
      int     ylen;
      int     mlen;
      cal_t   c;
      local_s = longint'(secs) + longint'(offset) * SECS_PER_HOUR;
      // before the epoch in local time: pinned to 1970-01-01 00:00:00
      if (local_s < 0) local_s = 0;
      days = local_s / SECS_PER_DAY;
      sod  = local_s % SECS_PER_DAY;
      // the epoch day was a thursday
      c.weekday = 3'((days + 3) % 7 + 1);
      yr = 1970;
      forever begin
        ylen = leap_year(yr) ? DAYS_LEAP_YR : DAYS_NORM_YR;
        if (days < ylen) break;
        days -= ylen;
        yr++;
      end
      mo = 0;
      forever begin
        case (mo)
          1:         mlen = leap_year(yr) ? 29 : 28;
          3, 5, 8, 10: mlen = 30;
          default:   mlen = 31;
        endcase
        if (days < mlen || mo == 11) break;
        days -= mlen;
        mo++;
      end
      c.year   = 12'(yr);
      c.month  = 4'(mo + 1);
      c.day    = 5'(days + 1);
      c.hour   = 5'(sod / SECS_PER_HOUR);
      c.minute = 6'((sod / SECS_PER_MIN) % 60);
      c.second = 6'(sod % SECS_PER_MIN);
      return c;
    endfunction

    function void note_stamp(logic [EPOCH_W-1:0] secs);
      due_t d;
      d.secs = secs;
      d.cal  = local_calendar(secs);
      due_dates.push_back(d);
      noted++;
    endfunction

    function void check_date(cal_t got);
      due_t d;
      bit   bad;
      if (due_dates.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("unexpected date %0d-%0d-%0d %0d:%0d:%0d wd %0d", got.year, got.month,
                   got.day, got.hour, got.minute, got.second, got.weekday);
        return;
      end
      d = due_dates.pop_front();
      checked++;
      bad = (got.year != d.cal.year) || (got.month != d.cal.month) ||
            (got.day != d.cal.day) || (got.hour != d.cal.hour) ||
            (got.minute != d.cal.minute) || (got.second != d.cal.second) ||
            (got.weekday != d.cal.weekday);
      if (bad) begin
        errors++;
        if (errors <= REPORT_MAX) begin
          $display("stamp %0d offset %0d: wanted %0d-%0d-%0d %0d:%0d:%0d wd %0d",
                   d.secs, offset, d.cal.year, d.cal.month, d.cal.day, d.cal.hour,
                   d.cal.minute, d.cal.second, d.cal.weekday);
          $display("  got %0d-%0d-%0d %0d:%0d:%0d wd %0d", got.year, got.month,
                   got.day, got.hour, got.minute, got.second, got.weekday);
        end
      end
    endfunction

    function int pending();
      return due_dates.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  int   cycle_count = 0;
  int   settings_used;
  bit   sender_calm;

  e2c_chan_if #(.data_t(stamp_t))  stamp_ch ();
  e2c_chan_if #(.data_t(cal_t))    date_ch ();
  e2c_chan_if #(.data_t(offset_t)) cfg_ch ();

  cal_scoreboard tracker;

  epoch_to_calendar_weekday dut (
    .clk   (clk),
    .rst   (rst),
    .stamp (stamp_ch),
    .date  (date_ch),
    .cfg   (cfg_ch)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d dates still owed", cycle_count,
               tracker.pending());
      $display("FAIL epoch_to_calendar_weekday");
      $finish;
    end
  end

  // one stamp word; a gap drops valid first, otherwise valid stays up back to back
  task automatic send_stamp(logic [EPOCH_W-1:0] secs);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(9, 0);
    if (gap > 0) begin
      stamp_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    stamp_ch.valid              <= 1'b1;
    stamp_ch.data.epoch_seconds <= secs;
    do @(posedge clk); while (!stamp_ch.ready);
    tracker.note_stamp(secs);
  endtask

  // stop sending and let every owed date come out
  task automatic wait_drained();
    stamp_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // offset writes only happen with the converter empty
  task automatic write_offset(offset_t value);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid   <= 1'b0;
    tracker.offset = value;
    settings_used++;
  endtask

  // result side: random stall before each word, with stretches of none
  initial begin
    int stall;
    int taken;
    bit calm;
    date_ch.ready = 1'b0;
    taken = 0;
    calm  = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (taken % 64 == 0) calm = ($urandom_range(3, 0) == 0);
      stall = calm ? 0 : $urandom_range(9, 0);
      if (stall > 0) begin
        date_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      date_ch.ready <= 1'b1;
      do @(posedge clk); while (!date_ch.valid);
      tracker.check_date(date_ch.data);
      taken++;
    end
  end

  initial begin
    logic [EPOCH_W-1:0] picks[$];
    offset_t            plan[PHASES];
    logic [EPOCH_W-1:0] secs;
    longint             near;
    int                 per_phase;
    rst            = 1'b1;
    settings_used  = 1;
    sender_calm    = 1'b0;
    stamp_ch.valid = 1'b0;
    stamp_ch.data  = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.data    = '0;
    tracker        = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset offset of +8: epoch, top of range, first and last seconds of a day
    picks = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'd86399};
    foreach (picks[i]) send_stamp(picks[i]);

    // utc: minute, hour and day rollovers, year end, feb 29 of 2000,
    // end of a leap year, and 2100 which has no feb 29
    write_offset(offset_t'(0));
    picks = '{32'd59, 32'd60, 32'd3599, 32'd86399, 32'd86400, 32'd94694399,
              32'd951782400, 32'd978307199, 32'd4107542399, 32'd4107542400};
    foreach (picks[i]) send_stamp(picks[i]);

    // west of utc: stamps that land before the epoch in local time clamp to it
    write_offset(offset_t'(-12));
    picks = '{32'd0, 32'd43199, 32'd43200};
    foreach (picks[i]) send_stamp(picks[i]);

    // most negative register value, outside the usual zone range
    write_offset(offset_t'(-16));
    picks = '{32'd57599, 32'd57600};
    foreach (picks[i]) send_stamp(picks[i]);

    // east offsets push the local time past 2^32 - 1
    write_offset(offset_t'(15));
    send_stamp(32'hFFFF_FFFF);
    write_offset(offset_t'(14));
    picks = '{32'hFFFF_FFFF, 32'd0};
    foreach (picks[i]) send_stamp(picks[i]);

    // random phases, one offset each, the last one drawn at random
    plan      = '{offset_t'(8), offset_t'(-12), offset_t'(14), offset_t'(-16),
                  offset_t'(15), offset_t'($urandom_range(31, 0))};
    per_phase = RANDOM_WORDS / PHASES;
    foreach (plan[p]) begin
      write_offset(plan[p]);
      for (int n = 0; n < per_phase; n++) begin
        if (n % 100 == 0) sender_calm = ($urandom_range(3, 0) == 0);
        // now and then hold off until the converter has emptied
        if ($urandom_range(149, 0) == 0) wait_drained();
        case ($urandom_range(9, 0))
          0, 1: begin
            // close to a local midnight, so day, month and year edges get hit
            near = longint'($urandom_range(49710, 0)) * SECS_PER_DAY
                   - longint'(tracker.offset) * SECS_PER_HOUR
                   + longint'($urandom_range(4, 0)) - 2;
            secs = near[EPOCH_W-1:0];
          end
          2:       secs = $urandom_range(200000, 0);
          3:       secs = 32'hFFFF_FFFF - $urandom_range(200000, 0);
          default: secs = $urandom;
        endcase
        send_stamp(secs);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("converted %0d stamps under %0d offset settings, %0d dates checked",
             tracker.noted, settings_used, tracker.checked);
    $display("%0d failures, %0d dates left owed", tracker.errors, tracker.pending());
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("PASS epoch_to_calendar_weekday");
    end else begin
      $display("FAIL epoch_to_calendar_weekday");
    end
    $finish;
  end

endmodule
